FILE: hdl/snfd_pkg.sv
// Shared types, constants and decode helpers for the pad frame decoder.
package snfd_pkg;

	// Adapter mode codes; the unused fourth code decodes as standard.
	localparam logic [1:0] MODE_STD  = 2'd0;
	localparam logic [1:0] MODE_MTAP = 2'd1;
	localparam logic [1:0] MODE_FS   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ADAPTER_MODE   = 2'd0;
	localparam logic [1:0] REG_LIVE_DETECT    = 2'd1;
	localparam logic [1:0] REG_FIXED_NES_MASK = 2'd2;

	// Frame lengths in bit slots.
	localparam logic [5:0] LEN_STD  = 6'd16;
	localparam logic [5:0] LEN_MTAP = 6'd32;
	localparam logic [5:0] LEN_FS   = 6'd24;

	localparam logic [7:0] AXIS_CENTER = 8'd128;
	localparam logic [7:0] AXIS_MAX    = 8'd255;
	localparam logic [7:0] AXIS_MIN    = 8'd0;
	localparam logic [7:0] BYTE_ONES   = 8'hFF;
	localparam logic [7:0] HI_NIBBLE   = 8'hF0;

	// One queued frame snapshot, or a plain bit slot that carries no report.
	typedef struct packed {
		logic            report;
		logic            sel;
		logic            four_score;
		logic [3:0]      nes;
		logic [3:0][7:0] first_bytes;
		logic [3:0][7:0] second_bytes;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	function automatic logic [7:0] axis_from(input logic plus, input logic minus);
		logic [7:0] v;
		v = AXIS_CENTER;
		if (plus) v = AXIS_MAX;
		if (minus) v = AXIS_MIN;
		return v;
	endfunction

	// B, Y, Select, Start into bits 0..3; low nibble of second byte above.
	function automatic logic [7:0] pack_snes(input logic [7:0] b0, input logic [7:0] b1);
		return {b1[3:0], b0[4], b0[5], b0[6], b0[7]};
	endfunction

endpackage

FILE: hdl/snfd_front.sv
// Front part: shifts bit slots into controller bytes and queues frame snapshots.
module snfd_front
	import snfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  adapter_mode,
	input  logic        live_detect,
	input  logic [3:0]  fixed_nes_mask,
	input  logic        take,
	input  logic [3:0]  line_levels,
	input  logic        frame_start,
	output entry_t      entry
);

	logic [5:0]      slot_count_q;
	logic [3:0][7:0] first_q;
	logic [3:0][7:0] second_q;

	logic [1:0]      mode;
	logic [5:0]      len;
	logic [5:0]      slot;
	logic [5:0]      slot_next;
	logic [3:0]      pressed;
	logic            in_slot;
	logic            frame_end;
	logic [3:0]      en_first;
	logic [3:0]      en_second;
	logic [3:0]      bit_in;
	logic [3:0]      flags;
	logic [3:0][7:0] first_nx;
	logic [3:0][7:0] second_nx;
	logic [3:0][7:0] second_fin;

	always_comb begin
		logic [1:0] pi;
		mode = (adapter_mode == MODE_MTAP || adapter_mode == MODE_FS) ? adapter_mode : MODE_STD;
		len = (mode == MODE_MTAP) ? LEN_MTAP : ((mode == MODE_FS) ? LEN_FS : LEN_STD);
		slot = frame_start ? 6'd0 : slot_count_q;
		pressed = ~line_levels;
		in_slot = (slot < len);
		slot_next = in_slot ? slot + 6'd1 : slot;
		frame_end = in_slot && (slot_next == len);
		en_first = '0;
		en_second = '0;
		bit_in = '0;
		for (int p = 0; p < 4; p++) begin
			pi = 2'(p);
			if (in_slot) begin
				if (mode == MODE_MTAP) begin
					if (pi[1] == slot[4]) begin
						bit_in[p] = pressed[pi[0]];
						en_first[p] = !slot[3];
						en_second[p] = slot[3];
					end
				end else if (mode == MODE_FS) begin
					if (slot[5:4] == 2'd0 && pi[1] == slot[3]) begin
						bit_in[p] = pressed[pi[0]];
						en_first[p] = 1'b1;
					end
				end else begin
					bit_in[p] = pressed[p];
					en_first[p] = (slot < 6'd8);
					en_second[p] = !(slot < 6'd8);
				end
			end
			first_nx[p] = en_first[p] ? {first_q[p][6:0], bit_in[p]} : first_q[p];
			second_nx[p] = en_second[p] ? {bit_in[p], second_q[p][7:1]} : second_q[p];
		end
		// Detect NES pads on the completed second bytes, then clear those bytes.
		for (int p = 0; p < 4; p++) begin
			flags[p] = live_detect ? (second_nx[p] == BYTE_ONES) : fixed_nes_mask[p];
		end
		if (!(frame_end && mode != MODE_FS)) flags = '0;
		for (int p = 0; p < 4; p++) begin
			second_fin[p] = flags[p] ? 8'd0 : second_nx[p];
		end
		entry.report = frame_end;
		entry.sel = (mode != MODE_MTAP) || (slot_next[5:4] == 2'd0) || (slot_next >= len);
		entry.four_score = (mode == MODE_FS);
		entry.nes = flags;
		entry.first_bytes = first_nx;
		entry.second_bytes = second_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			first_q <= '0;
			second_q <= '0;
		end else if (take) begin
			slot_count_q <= slot_next;
			first_q <= first_nx;
			second_q <= second_fin;
		end
	end

endmodule

FILE: hdl/snfd_queue.sv
// Small FIFO of frame entries between the front and back parts.
module snfd_queue
	import snfd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    wr_entry,
	input  logic      pop,
	output entry_t    rd_entry,
	output q_status_t status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.not_empty = (count_q != '0);
	assign status.full = (count_q == FULL_CNT);
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

FILE: hdl/snfd_back.sv
// Back part: expands queued entries into results and tracks reported bytes.
module snfd_back
	import snfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t status,
	input  entry_t    head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      select_level,
	output logic      report_valid,
	output logic [2:0] pad_number,
	output logic [7:0] axis_x,
	output logic [7:0] axis_y,
	output logic [7:0] button_bits,
	output logic      pad_changed,
	output logic      last
);

	logic [1:0]       pad_q;
	logic [3:0][15:0] reported_q;
	logic             out_valid_q;

	logic             load;
	logic             issue;
	logic [7:0]       b0;
	logic [7:0]       b1;
	logic             changed;
	logic [15:0]      new_rep;
	logic [7:0]       buttons;

	assign load = !out_valid_q || out_ready;
	assign issue = load && status.not_empty;
	assign pop = issue && (!head.report || pad_q == 2'd3);
	assign out_valid = out_valid_q;

	always_comb begin
		b0 = head.first_bytes[pad_q];
		b1 = head.second_bytes[pad_q];
		if (head.four_score) begin
			changed = (reported_q[pad_q][7:0] != b0);
			new_rep = {8'd0, b0};
		end else begin
			changed = (reported_q[pad_q] != {b1, b0});
			new_rep = {b1, b0};
		end
		buttons = (head.four_score || head.nes[pad_q]) ? (b0 & HI_NIBBLE) : pack_snes(b0, b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
			reported_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= status.not_empty;
			if (issue && head.report) begin
				reported_q[pad_q] <= new_rep;
				pad_q <= pad_q + 2'd1;
			end
		end
	end

	// Result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (issue) begin
			select_level <= head.sel;
			report_valid <= head.report;
			last <= !head.report || pad_q == 2'd3;
			if (head.report) begin
				pad_number <= {1'b0, pad_q} + 3'd1;
				axis_x <= axis_from(b0[0], b0[1]);
				axis_y <= axis_from(b0[2], b0[3]);
				button_bits <= buttons;
				pad_changed <= changed;
			end else begin
				pad_number <= '0;
				axis_x <= '0;
				axis_y <= '0;
				button_bits <= '0;
				pad_changed <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/snes_nes_pad_frame_decoder.sv
// Top level of the SNES/NES pad frame decoder: config registers, front, queue, back.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -------------------------------------------------
//  in       in_valid / in_ready    line_levels, frame_start (one bit slot)
//  out      out_valid / out_ready  select_level, report_valid, pad_number, axis_x,
//                                  axis_y, button_bits, pad_changed, last
//  cfg      cfg_wr_en              cfg_index, cfg_data (write only)
//
// One bit slot is accepted per cycle while the entry queue has room; the front
// finishes its shift in that cycle and queues one entry per slot.
// The back drains one entry per cycle for plain slots while the output can load, and
// holds a frame-end entry until it has issued one report per pad; results are registered.
// Reset clears slot position, controller bytes, reported bytes and the queue.
// Either side may stall: the queue and the output register absorb the difference.
module snes_nes_pad_frame_decoder
	import snfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] line_levels,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       select_level,
	output logic       report_valid,
	output logic [2:0] pad_number,
	output logic [7:0] axis_x,
	output logic [7:0] axis_y,
	output logic [7:0] button_bits,
	output logic       pad_changed,
	output logic       last
);

	// Configuration registers.
	logic [1:0] adapter_mode_q;
	logic       live_detect_q;
	logic [3:0] fixed_nes_mask_q;

	logic      take;
	logic      pop;
	entry_t    front_entry;
	entry_t    head_entry;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapter_mode_q <= MODE_STD;
			live_detect_q <= 1'b1;
			fixed_nes_mask_q <= '0;
		end else if (cfg_wr_en) begin
			// Drop writes to indexes beyond the register list.
			if (cfg_index == REG_ADAPTER_MODE) adapter_mode_q <= cfg_data[1:0];
			if (cfg_index == REG_LIVE_DETECT) live_detect_q <= cfg_data[0];
			if (cfg_index == REG_FIXED_NES_MASK) fixed_nes_mask_q <= cfg_data;
		end
	end

	// Accept a slot whenever the queue can hold its entry.
	assign in_ready = !q_status.full;
	assign take = in_valid && in_ready;

	snfd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.adapter_mode   (adapter_mode_q),
		.live_detect    (live_detect_q),
		.fixed_nes_mask (fixed_nes_mask_q),
		.take           (take),
		.line_levels    (line_levels),
		.frame_start    (frame_start),
		.entry          (front_entry)
	);

	snfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.wr_entry (front_entry),
		.pop      (pop),
		.rd_entry (head_entry),
		.status   (q_status)
	);

	snfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (q_status),
		.head         (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.select_level (select_level),
		.report_valid (report_valid),
		.pad_number   (pad_number),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.button_bits  (button_bits),
		.pad_changed  (pad_changed),
		.last         (last)
	);

endmodule
